### src/pcsm_pkg.sv
package pcsm_pkg;
  localparam int STACK_DEPTH = 1024;
  localparam int PROGRAM_SIZE = 2048;
  localparam int DATA_WIDTH = 32;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int PAW = $clog2(PROGRAM_SIZE);
  localparam int TW = SAW + 1;

  typedef enum logic [2:0] {
    OP_LIT = 3'd0, OP_OPR = 3'd1, OP_LOD = 3'd2, OP_STO = 3'd3,
    OP_CAL = 3'd4, OP_INT = 3'd5, OP_JMP = 3'd6, OP_JPC = 3'd7
  } op_t;

  localparam logic [10:0] OPR_RET = 11'd0;
  localparam logic [10:0] OPR_NEG = 11'd1;
  localparam logic [10:0] OPR_ADD = 11'd2;
  localparam logic [10:0] OPR_SUB = 11'd3;
  localparam logic [10:0] OPR_MUL = 11'd4;
  localparam logic [10:0] OPR_DIV = 11'd5;
  localparam logic [10:0] OPR_ODD = 11'd6;
  localparam logic [10:0] OPR_EQ = 11'd8;
  localparam logic [10:0] OPR_NE = 11'd9;
  localparam logic [10:0] OPR_LT = 11'd10;
  localparam logic [10:0] OPR_GE = 11'd11;
  localparam logic [10:0] OPR_GT = 11'd12;
  localparam logic [10:0] OPR_LE = 11'd13;

  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_DIV0 = 2'd1;
  localparam logic [1:0] FLT_RANGE = 2'd2;
endpackage

### src/pcsm_divider.sv
module pcsm_divider
  import pcsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);
  localparam int CW = $clog2(DATA_WIDTH + 1);
  logic [DATA_WIDTH-1:0] q_r, d_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic neg_r, busy_r, done_r;
  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH-1:0] mx, my;

  always_comb begin
    mx = dividend[DATA_WIDTH-1] ? -dividend : dividend;
    my = divisor[DATA_WIDTH-1] ? -divisor : divisor;
    trial = {rem_r, q_r[DATA_WIDTH-1]} - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r <= mx;
        d_r <= my;
        rem_r <= '0;
        neg_r <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        cnt_r <= CW'(DATA_WIDTH);
      end else if (busy_r) begin
        if (!trial[DATA_WIDTH]) begin
          rem_r <= trial[DATA_WIDTH-1:0];
          q_r <= {q_r[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DATA_WIDTH-2:0], q_r[DATA_WIDTH-1]};
          q_r <= {q_r[DATA_WIDTH-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quotient = neg_r ? -q_r : q_r;
endmodule

### src/pcsm_stack_ram.sv
module pcsm_stack_ram
  import pcsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [SAW-1:0]        waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [SAW-1:0]        raddr,
  output logic [DATA_WIDTH-1:0] rdata
);
  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/pcode_stack_machine_execute.sv
// PL/0 p-code execution unit. One instruction (operation, level, operand)
// enters per item; one result item leaves with next fetch address, top of
// stack word, top and base registers, halted flag and fault code. The stack
// lives in one single-port-read, one-write synchronous RAM, so every stack
// access is one sequencer step. Each static link walked (LOD, STO, CAL)
// waits out the registered RAM address and data; two-operand OPR adds a
// write step, CAL two more writes, and DIV runs the bit-serial
// divider. The next item is taken only once the result is consumed, so
// a new instruction is never taken before the last one is through. After
// reset the RAM is swept to zero, one word per cycle, while in_ready
// stays low. Faults leave stack and registers unchanged and only advance
// the program counter.
module pcode_stack_machine_execute
  import pcsm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_operation,
  input  logic [1:0]                   in_level,
  input  logic [10:0]                  in_operand,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [10:0]                  out_next_address,
  output logic signed [31:0]           out_top_value,
  output logic signed [10:0]           out_top_index,
  output logic [9:0]                   out_frame_base,
  output logic                         out_halted,
  output logic [1:0]                   out_fault
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LWAIT, S_LINK, S_RD1, S_RD2, S_EXEC, S_DIV, S_WR2, S_WR3,
    S_TOP, S_TOPW, S_OUT
  } state_t;

  state_t state_r;
  logic [SAW-1:0] clr_r;
  logic [2:0] op_r;
  logic [1:0] lev_r;
  logic [10:0] arg_r;
  logic signed [TW-1:0] t_r, t_new_r;
  logic [SAW-1:0] b_r, b_new_r, link_r;
  logic [PAW-1:0] pc_r, p_new_r;
  logic [DATA_WIDTH-1:0] x_r, y_r;
  logic [1:0] flt_r;
  logic [DATA_WIDTH-1:0] top_r;
  logic out_valid_r;

  logic we;
  logic [SAW-1:0] waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic div_start, div_done;
  logic [DATA_WIDTH-1:0] quo;

  pcsm_stack_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);
  // divisor is the top word, on rdata in S_EXEC
  pcsm_divider u_div (.clk, .rst_n, .start(div_start), .dividend(x_r),
    .divisor(rdata), .done(div_done), .quotient(quo));

  // read-address register: drives RAM read issued for next state
  logic [SAW-1:0] ra_r;
  assign raddr = ra_r;

  // wide helpers
  logic [TW+11:0] sum_l;  // link + arg etc
  logic signed [TW+1:0] t_ext;
  logic [PAW-1:0] p_inc;
  logic [DATA_WIDTH-1:0] sb;
  logic [DATA_WIDTH-1:0] r_alu;
  logic [2*DATA_WIDTH-1:0] prod;

  always_comb begin
    sb = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    p_inc = pc_r + 1'b1;
    t_ext = (TW+2)'(t_r);
    prod = x_r * y_r;
    case (arg_r)
      OPR_ADD: r_alu = x_r + y_r;
      OPR_SUB: r_alu = x_r - y_r;
      OPR_MUL: r_alu = prod[DATA_WIDTH-1:0];
      OPR_EQ: r_alu = DATA_WIDTH'(x_r == y_r);
      OPR_NE: r_alu = DATA_WIDTH'(x_r != y_r);
      OPR_LT: r_alu = DATA_WIDTH'((x_r ^ sb) < (y_r ^ sb));
      OPR_GE: r_alu = DATA_WIDTH'((x_r ^ sb) >= (y_r ^ sb));
      OPR_GT: r_alu = DATA_WIDTH'((x_r ^ sb) > (y_r ^ sb));
      default: r_alu = DATA_WIDTH'((x_r ^ sb) <= (y_r ^ sb));
    endcase
    sum_l = (TW+12)'(link_r) + (TW+12)'(arg_r);
  end

  logic is_bin;
  assign is_bin = (arg_r >= OPR_ADD && arg_r <= OPR_DIV) ||
                  (arg_r >= OPR_EQ && arg_r <= OPR_LE);

  // write port registered by sequencer
  logic we_r;
  logic [SAW-1:0] wa_r;
  logic [DATA_WIDTH-1:0] wd_r;
  assign we = (state_r == S_CLEAR) ? 1'b1 : we_r;
  assign waddr = (state_r == S_CLEAR) ? clr_r : wa_r;
  assign wdata = (state_r == S_CLEAR) ? '0 : wd_r;
  assign div_start = (state_r == S_EXEC) && (op_r == OP_OPR) && (arg_r == OPR_DIV)
                     && (t_r >= 1) && (rdata != '0);

  logic [TW+1:0] depth_x;
  assign depth_x = (TW+2)'(STACK_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      t_r <= '1;
      b_r <= '0;
      pc_r <= '0;
      out_valid_r <= 1'b0;
      we_r <= 1'b0;
      top_r <= '0;
    end else begin
      we_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SAW'(STACK_DEPTH-1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_r <= in_operation;
            lev_r <= in_level;
            arg_r <= in_operand;
            link_r <= b_r;
            t_new_r <= t_r;
            b_new_r <= b_r;
            p_new_r <= pc_r + 1'b1;
            flt_r <= FLT_NONE;
            ra_r <= b_r;
            state_r <= S_LWAIT;
          end
        end
        // RAM samples ra_r here; data shows up for S_LINK
        S_LWAIT: state_r <= S_LINK;
        S_LINK: begin
          // ra_r was sampled by the RAM in S_LWAIT; rdata valid now for link reads
          if ((op_r == OP_LOD || op_r == OP_STO || op_r == OP_CAL) &&
              lev_r != 2'd0) begin
            if (rdata >= DATA_WIDTH'(STACK_DEPTH)) begin
              flt_r <= FLT_RANGE;
              state_r <= S_TOP;
            end else begin
              link_r <= rdata[SAW-1:0];
              ra_r <= rdata[SAW-1:0];
              lev_r <= lev_r - 1'b1;
              state_r <= S_LWAIT;
            end
          end else begin
            state_r <= S_RD1;
            // choose first operand address
            case (op_r)
              OP_OPR: ra_r <= (arg_r == OPR_RET) ? b_r + 1'b1 : t_r[SAW-1:0] - 1'b1;
              OP_LOD: ra_r <= sum_l[SAW-1:0];
              default: ra_r <= t_r[SAW-1:0];
            endcase
          end
        end
        S_RD1: begin
          // wait for RAM read
          state_r <= S_RD2;
          if (op_r == OP_OPR && arg_r == OPR_RET) ra_r <= b_r + 2'd2;
          else ra_r <= t_r[SAW-1:0];
        end
        S_RD2: begin
          x_r <= rdata;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          y_r <= rdata;
          state_r <= S_TOP;
          case (op_r)
            OP_LIT: begin
              if (t_ext + 1 >= $signed(depth_x)) flt_r <= FLT_RANGE;
              else begin
                t_new_r <= t_r + 1'b1;
                we_r <= 1'b1; wa_r <= SAW'(t_r + 1'b1);
                wd_r <= DATA_WIDTH'(arg_r);
              end
            end
            OP_OPR: begin
              if (arg_r == OPR_RET) begin
                if ((TW+2)'(b_r) + 2 >= depth_x || x_r >= DATA_WIDTH'(STACK_DEPTH))
                  flt_r <= FLT_RANGE;
                else begin
                  t_new_r <= TW'(b_r) - 1'b1;
                  b_new_r <= x_r[SAW-1:0];
                  p_new_r <= rdata[PAW-1:0];
                end
              end else if (arg_r == OPR_NEG || arg_r == OPR_ODD) begin
                if (t_r < 0) flt_r <= FLT_RANGE;
                else begin
                  we_r <= 1'b1; wa_r <= t_r[SAW-1:0];
                  wd_r <= (arg_r == OPR_NEG) ? -rdata : {{(DATA_WIDTH-1){1'b0}}, rdata[0]};
                end
              end else if (is_bin) begin
                if (t_r < 1) flt_r <= FLT_RANGE;
                else if (arg_r == OPR_DIV && rdata == '0) flt_r <= FLT_DIV0;
                else if (arg_r == OPR_DIV) state_r <= S_DIV;
                else state_r <= S_WR2;
              end
            end
            OP_LOD: begin
              if (sum_l >= (TW+12)'(STACK_DEPTH) || t_ext + 1 >= $signed(depth_x))
                flt_r <= FLT_RANGE;
              else begin
                t_new_r <= t_r + 1'b1;
                we_r <= 1'b1; wa_r <= SAW'(t_r + 1'b1); wd_r <= x_r;
              end
            end
            OP_STO: begin
              if (sum_l >= (TW+12)'(STACK_DEPTH) || t_r < 0) flt_r <= FLT_RANGE;
              else begin
                t_new_r <= t_r - 1'b1;
                we_r <= 1'b1; wa_r <= sum_l[SAW-1:0]; wd_r <= rdata;
              end
            end
            OP_CAL: begin
              if (t_ext + 3 >= $signed(depth_x)) flt_r <= FLT_RANGE;
              else begin
                we_r <= 1'b1; wa_r <= SAW'(t_r + 1'b1);
                wd_r <= DATA_WIDTH'(link_r);
                state_r <= S_WR3;
              end
            end
            OP_INT: begin
              if (t_ext + $signed((TW+2)'(arg_r)) >= $signed(depth_x)) flt_r <= FLT_RANGE;
              else t_new_r <= TW'(t_ext + $signed((TW+2)'(arg_r)));
            end
            OP_JMP: p_new_r <= arg_r[PAW-1:0];
            default: begin
              if (t_r < 0) flt_r <= FLT_RANGE;
              else begin
                if (rdata != '0) p_new_r <= arg_r[PAW-1:0];
                t_new_r <= t_r - 1'b1;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            x_r <= quo;
            state_r <= S_WR2;
          end
        end
        S_WR2: begin
          t_new_r <= t_r - 1'b1;
          we_r <= 1'b1; wa_r <= SAW'(t_r - 1'b1);
          wd_r <= (arg_r == OPR_DIV) ? x_r : r_alu;
          state_r <= S_TOP;
        end
        S_WR3: begin
          // CAL: dynamic link then return address
          if (wa_r == SAW'(t_r + 1'b1)) begin
            we_r <= 1'b1; wa_r <= SAW'(t_r + 2'd2); wd_r <= DATA_WIDTH'(b_r);
          end else begin
            we_r <= 1'b1; wa_r <= SAW'(t_r + 2'd3); wd_r <= DATA_WIDTH'(p_inc);
            b_new_r <= SAW'(t_r + 1'b1);
            p_new_r <= arg_r[PAW-1:0];
            state_r <= S_TOP;
          end
        end
        S_TOP: begin
          // commit registers (faults keep them), read new top
          if (flt_r == FLT_NONE) begin
            t_r <= t_new_r;
            b_r <= b_new_r;
            ra_r <= t_new_r[SAW-1:0];
          end else ra_r <= t_r[SAW-1:0];
          pc_r <= (flt_r == FLT_NONE) ? p_new_r : p_inc;
          state_r <= S_TOPW;
        end
        S_TOPW: state_r <= S_OUT;
        S_OUT: begin
          top_r <= (t_r < 0) ? '0 : rdata;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // hold in_ready low while a result is pending so results are not overwritten
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_next_address = 11'(pc_r);
  assign out_top_value = top_r;
  assign out_top_index = 11'(t_r);
  assign out_frame_base = 10'(b_r);
  assign out_halted = (pc_r == '0);
  assign out_fault = flt_r;
endmodule
